>>> rtl/wfpd_pkg.sv
// ----------------------------------------------------------------------------
// wfpd_pkg
// Shared widths, register indexes, mode codes and reset values of the
// wall-following PD drive controller.
// ----------------------------------------------------------------------------
package wfpd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int GAIN_W     = 16;
    localparam int DIV_W      = 16;
    localparam int SPEED_W    = 8;
    localparam int SETPOINT_W = 12;
    localparam int MODE_W     = 2;

    localparam int QUOT_W       = 11;
    localparam int QCNT_W       = 4;
    localparam int BOOTH_DIGITS = GAIN_W / 2;
    localparam int DIGIT_W      = 3;
    localparam int NUM_TERMS    = 6;
    localparam int TERM_W       = 3;
    localparam int CTRL_W       = QUOT_W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_VEL_GAINS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_GAINS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_GAINS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMITS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd6;

    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BOTH  = 2'd3;

    localparam logic [DIV_W-1:0] DIVISOR_RST = 16'd1;
    localparam logic [15:0]      LIMITS_RST  = 16'hFF00;

endpackage

>>> rtl/wfpd_in_if.sv
// ----------------------------------------------------------------------------
// wfpd_in_if
// Input channel: one control tick item with encoder counts, IR readings,
// wall mode and restart flag.
// ----------------------------------------------------------------------------
interface wfpd_in_if #(
    parameter int TICK_WIDTH   = 24,
    parameter int SENSOR_WIDTH = 12
);
    import wfpd_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [TICK_WIDTH-1:0]   encoder_one;
    logic signed [TICK_WIDTH-1:0]   encoder_two;
    logic        [SENSOR_WIDTH-1:0] left_ir;
    logic        [SENSOR_WIDTH-1:0] right_ir;
    logic        [MODE_W-1:0]       mode;
    logic                           restart;

    modport source (
        output valid, encoder_one, encoder_two, left_ir, right_ir, mode, restart,
        input  ready
    );

    modport sink (
        input  valid, encoder_one, encoder_two, left_ir, right_ir, mode, restart,
        output ready
    );
endinterface

>>> rtl/wfpd_out_if.sv
// ----------------------------------------------------------------------------
// wfpd_out_if
// Output channel: one item with the two saturated motor speeds.
// ----------------------------------------------------------------------------
interface wfpd_out_if;
    import wfpd_pkg::*;

    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] motor_one_speed;
    logic [SPEED_W-1:0] motor_two_speed;

    modport source (
        output valid, motor_one_speed, motor_two_speed,
        input  ready
    );

    modport sink (
        input  valid, motor_one_speed, motor_two_speed,
        output ready
    );
endinterface

>>> rtl/wall_following_pd_drive_top.sv
// ----------------------------------------------------------------------------
// wall_following_pd_drive_top
// PD differential drive controller with wall following.
//
// Each item on i_cmd is one control tick; it yields exactly one item on
// o_drive with the two saturated motor speeds. Registers are written on the
// plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); the user must write them
// only while the block is idle, which the block itself does not enforce. An
// item passes in order through error and derivative arithmetic, the shared
// radix-4 Booth multiply-accumulate (six products, eight digits each), the
// magnitude step, divider setup, the restoring divider (one quotient bit per
// cycle) and saturation. A new item is accepted only once the previous one
// has been loaded into the output register. The output register holds a
// finished item while the receiver stalls; the next item is accepted and
// processed meanwhile and waits in the saturation stage until the register
// frees up. Reset clears the registers to their defaults, the error history
// and the output valid.
// ----------------------------------------------------------------------------
module wall_following_pd_drive_top #(
    parameter int TICK_WIDTH   = 24,
    parameter int SENSOR_WIDTH = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wfpd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wfpd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    wfpd_in_if.sink                          i_cmd,
    wfpd_out_if.source                       o_drive
);
    import wfpd_pkg::*;

    localparam int WALL_BASE = (SENSOR_WIDTH > SETPOINT_W) ? SENSOR_WIDTH : SETPOINT_W;
    localparam int WERR_W    = WALL_BASE + 1;
    localparam int WDER_W    = WERR_W + 1;
    localparam int AERR_W    = TICK_WIDTH + 1;
    localparam int ADER_W    = TICK_WIDTH + 2;
    localparam int VERR_W    = TICK_WIDTH + 2;
    localparam int VDER_W    = TICK_WIDTH + 3;
    localparam int OP_W      = (VDER_W > WDER_W) ? VDER_W : WDER_W;
    localparam int SUM_W     = OP_W + GAIN_W + 3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_DIFF,
        S_VDER,
        S_MAC,
        S_ABS,
        S_DPREP,
        S_DIV,
        S_CLAMP
    } t_state;

    t_state r_state;

    logic [CFG_DATA_W-1:0] r_vel_gains;
    logic [CFG_DATA_W-1:0] r_ang_gains;
    logic [CFG_DATA_W-1:0] r_wall_gains;
    logic [DIV_W-1:0]      r_divisor;
    logic [SPEED_W-1:0]    r_cruise;
    logic [15:0]           r_limits;
    logic [SETPOINT_W-1:0] r_setpoint;

    logic signed [TICK_WIDTH-1:0]   r_enc1;
    logic signed [TICK_WIDTH-1:0]   r_enc2;
    logic        [SENSOR_WIDTH-1:0] r_left;
    logic        [SENSOR_WIDTH-1:0] r_right;
    logic        [MODE_W-1:0]       r_mode;
    logic                           r_restart;

    logic signed [TICK_WIDTH-1:0] r_last1;
    logic signed [TICK_WIDTH-1:0] r_last2;
    logic signed [VERR_W-1:0]     r_last_verr;
    logic signed [AERR_W-1:0]     r_last_aerr;
    logic signed [WERR_W-1:0]     r_last_werr;
    logic        [MODE_W-1:0]     r_last_mode;

    logic signed [AERR_W-1:0] r_d1;
    logic signed [AERR_W-1:0] r_d2;
    logic signed [AERR_W-1:0] r_aerr;
    logic signed [WERR_W-1:0] r_werr;
    logic signed [VERR_W-1:0] r_pve;
    logic signed [AERR_W-1:0] r_pae;
    logic signed [WERR_W-1:0] r_pwe;
    logic signed [VERR_W-1:0] r_verr;
    logic signed [ADER_W-1:0] r_ader;
    logic signed [WDER_W-1:0] r_wder;
    logic signed [VDER_W-1:0] r_vder;

    logic [SUM_W-1:0]   r_acc;
    logic [SUM_W-1:0]   r_mcand;
    logic [GAIN_W-1:0]  r_mplr;
    logic               r_prev;
    logic [DIGIT_W-1:0] r_digit;
    logic [TERM_W-1:0]  r_term;

    logic               r_neg;
    logic [SUM_W-1:0]   r_mag;
    logic [DIV_W-1:0]   r_dvs;
    logic               r_ovf;
    logic [DIV_W-1:0]   r_rem;
    logic [QUOT_W-1:0]  r_qsh;
    logic [QCNT_W-1:0]  r_cnt;

    logic               r_out_valid;
    logic [SPEED_W-1:0] r_m1;
    logic [SPEED_W-1:0] r_m2;

    logic cmd_acc;
    logic clear_hist;
    logic out_free;

    logic signed [TICK_WIDTH-1:0] w_le1;
    logic signed [TICK_WIDTH-1:0] w_le2;
    logic signed [WERR_W-1:0]     w_left;
    logic signed [WERR_W-1:0]     w_right;
    logic signed [WERR_W-1:0]     w_target;
    logic signed [WERR_W-1:0]     w_werr;

    logic [TERM_W-1:0] w_load_idx;
    logic [SUM_W-1:0]  w_load_op;
    logic [GAIN_W-1:0] w_load_gain;

    logic [2:0]       w_booth;
    logic             w_zero;
    logic             w_two;
    logic             w_bneg;
    logic [SUM_W-1:0] w_pp;
    logic [SUM_W-1:0] w_acc_next;

    logic [DIV_W:0] w_trial;
    logic [DIV_W:0] w_diff;
    logic           w_ge;

    logic        [QUOT_W-1:0] w_quot;
    logic signed [CTRL_W-1:0] w_qext;
    logic signed [CTRL_W-1:0] w_ctrl;
    logic signed [CTRL_W-1:0] w_base;
    logic signed [CTRL_W-1:0] w_lo;
    logic signed [CTRL_W-1:0] w_hi;
    logic signed [CTRL_W-1:0] w_v1;
    logic signed [CTRL_W-1:0] w_v2;

    function automatic logic [SPEED_W-1:0] f_clamp(
        input logic signed [CTRL_W-1:0] v,
        input logic signed [CTRL_W-1:0] lo,
        input logic signed [CTRL_W-1:0] hi
    );
        if (v < lo) begin
            return lo[SPEED_W-1:0];
        end else if (v > hi) begin
            return hi[SPEED_W-1:0];
        end
        return v[SPEED_W-1:0];
    endfunction

    assign cmd_acc    = i_cmd.valid && i_cmd.ready;
    assign clear_hist = r_restart || (r_mode != r_last_mode);
    assign out_free   = !r_out_valid || o_drive.ready;

    assign i_cmd.ready             = (r_state == S_IDLE);
    assign o_drive.valid           = r_out_valid;
    assign o_drive.motor_one_speed = r_m1;
    assign o_drive.motor_two_speed = r_m2;

    // Error terms and the history seen by this tick.
    assign w_le1    = clear_hist ? r_enc1 : r_last1;
    assign w_le2    = clear_hist ? r_enc2 : r_last2;
    assign w_left   = WERR_W'(r_left);
    assign w_right  = WERR_W'(r_right);
    assign w_target = WERR_W'(r_setpoint);

    always_comb begin
        case (r_mode)
            MODE_LEFT:  w_werr = w_left - w_target;
            MODE_RIGHT: w_werr = w_target - w_right;
            MODE_BOTH:  w_werr = w_left - w_right;
            default:    w_werr = '0;
        endcase
    end

    // Operand and gain of the next product in the accumulation.
    assign w_load_idx = (r_state == S_VDER) ? '0 : TERM_W'(r_term + 1'b1);

    always_comb begin
        case (w_load_idx)
            3'd0: begin
                w_load_op   = SUM_W'(r_verr);
                w_load_gain = r_vel_gains[GAIN_W-1:0];
            end
            3'd1: begin
                w_load_op   = SUM_W'(r_vder);
                w_load_gain = r_vel_gains[2*GAIN_W-1:GAIN_W];
            end
            3'd2: begin
                w_load_op   = SUM_W'(r_aerr);
                w_load_gain = r_ang_gains[GAIN_W-1:0];
            end
            3'd3: begin
                w_load_op   = SUM_W'(r_ader);
                w_load_gain = r_ang_gains[2*GAIN_W-1:GAIN_W];
            end
            3'd4: begin
                w_load_op   = SUM_W'(r_werr);
                w_load_gain = r_wall_gains[GAIN_W-1:0];
            end
            3'd5: begin
                w_load_op   = SUM_W'(r_wder);
                w_load_gain = r_wall_gains[2*GAIN_W-1:GAIN_W];
            end
            default: begin
                w_load_op   = '0;
                w_load_gain = '0;
            end
        endcase
    end

    // Radix-4 Booth recoding of two multiplier bits per cycle.
    assign w_booth    = {r_mplr[1:0], r_prev};
    assign w_zero     = (w_booth == 3'b000) || (w_booth == 3'b111);
    assign w_two      = (w_booth == 3'b011) || (w_booth == 3'b100);
    assign w_bneg     = w_booth[2] && !(w_booth[1] && w_booth[0]);
    assign w_pp       = w_zero ? '0 : (w_two ? (r_mcand << 1) : r_mcand);
    assign w_acc_next = r_acc + (w_bneg ? ~w_pp : w_pp) + SUM_W'(w_bneg);

    // Restoring divider step.
    assign w_trial = {r_rem, r_qsh[QUOT_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    // Sign, base speed and saturation.
    assign w_quot = r_ovf ? '1 : r_qsh;
    assign w_qext = CTRL_W'(w_quot);
    assign w_ctrl = r_neg ? -w_qext : w_qext;
    assign w_base = CTRL_W'(r_cruise);
    assign w_lo   = CTRL_W'(r_limits[SPEED_W-1:0]);
    assign w_hi   = CTRL_W'(r_limits[2*SPEED_W-1:SPEED_W]);
    assign w_v1   = w_base + w_ctrl;
    assign w_v2   = w_base - w_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_gains  <= '0;
            r_ang_gains  <= '0;
            r_wall_gains <= '0;
            r_divisor    <= DIVISOR_RST;
            r_cruise     <= '0;
            r_limits     <= LIMITS_RST;
            r_setpoint   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_VEL_GAINS:  r_vel_gains  <= i_cfg_data;
                REG_ANG_GAINS:  r_ang_gains  <= i_cfg_data;
                REG_WALL_GAINS: r_wall_gains <= i_cfg_data;
                REG_DIVISOR:    r_divisor    <= i_cfg_data[DIV_W-1:0];
                REG_CRUISE:     r_cruise     <= i_cfg_data[SPEED_W-1:0];
                REG_LIMITS:     r_limits     <= i_cfg_data[15:0];
                REG_SETPOINT:   r_setpoint   <= i_cfg_data[SETPOINT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last1     <= '0;
            r_last2     <= '0;
            r_last_verr <= '0;
            r_last_aerr <= '0;
            r_last_werr <= '0;
            r_last_mode <= '0;
            r_digit     <= '0;
            r_term      <= '0;
            r_cnt       <= '0;
        end else begin
            if ((r_state == S_CLAMP) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_drive.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (cmd_acc) begin
                        r_enc1    <= i_cmd.encoder_one;
                        r_enc2    <= i_cmd.encoder_two;
                        r_left    <= i_cmd.left_ir;
                        r_right   <= i_cmd.right_ir;
                        r_mode    <= i_cmd.mode;
                        r_restart <= i_cmd.restart;
                        r_state   <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_d1        <= AERR_W'(r_enc1) - AERR_W'(w_le1);
                    r_d2        <= AERR_W'(r_enc2) - AERR_W'(w_le2);
                    r_aerr      <= AERR_W'(r_enc2) - AERR_W'(r_enc1);
                    r_werr      <= w_werr;
                    r_pve       <= clear_hist ? '0 : r_last_verr;
                    r_pae       <= clear_hist ? '0 : r_last_aerr;
                    r_pwe       <= clear_hist ? '0 : r_last_werr;
                    r_last1     <= r_enc1;
                    r_last2     <= r_enc2;
                    r_last_mode <= r_mode;
                    r_state     <= S_DIFF;
                end
                S_DIFF: begin
                    r_verr      <= VERR_W'(r_d2) - VERR_W'(r_d1);
                    r_ader      <= ADER_W'(r_aerr) - ADER_W'(r_pae);
                    r_wder      <= WDER_W'(r_werr) - WDER_W'(r_pwe);
                    r_last_aerr <= r_aerr;
                    r_last_werr <= r_werr;
                    r_state     <= S_VDER;
                end
                S_VDER: begin
                    r_vder      <= VDER_W'(r_verr) - VDER_W'(r_pve);
                    r_last_verr <= r_verr;
                    r_acc       <= '0;
                    r_mcand     <= w_load_op;
                    r_mplr      <= w_load_gain;
                    r_prev      <= 1'b0;
                    r_term      <= w_load_idx;
                    r_digit     <= '0;
                    r_state     <= S_MAC;
                end
                S_MAC: begin
                    r_acc   <= w_acc_next;
                    r_digit <= DIGIT_W'(r_digit + 1'b1);
                    if ((r_digit == DIGIT_W'(BOOTH_DIGITS - 1)) &&
                        (r_term != TERM_W'(NUM_TERMS - 1))) begin
                        r_term  <= w_load_idx;
                        r_mcand <= w_load_op;
                        r_mplr  <= w_load_gain;
                        r_prev  <= 1'b0;
                    end else begin
                        r_mcand <= r_mcand << 2;
                        r_mplr  <= r_mplr >> 2;
                        r_prev  <= r_mplr[1];
                    end
                    if ((r_digit == DIGIT_W'(BOOTH_DIGITS - 1)) &&
                        (r_term == TERM_W'(NUM_TERMS - 1))) begin
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_neg   <= r_acc[SUM_W-1];
                    r_mag   <= r_acc[SUM_W-1] ? (~r_acc) + SUM_W'(1) : r_acc;
                    r_dvs   <= (r_divisor == '0) ? DIV_W'(1) : r_divisor;
                    r_state <= S_DPREP;
                end
                S_DPREP: begin
                    r_ovf   <= (r_mag[SUM_W-1:QUOT_W] >= (SUM_W - QUOT_W)'(r_dvs));
                    r_rem   <= r_mag[QUOT_W+DIV_W-1:QUOT_W];
                    r_qsh   <= r_mag[QUOT_W-1:0];
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
                    r_qsh <= {r_qsh[QUOT_W-2:0], w_ge};
                    r_cnt <= QCNT_W'(r_cnt + 1'b1);
                    if (r_cnt == QCNT_W'(QUOT_W - 1)) begin
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    if (out_free) begin
                        r_m1    <= f_clamp(w_v1, w_lo, w_hi);
                        r_m2    <= f_clamp(w_v2, w_lo, w_hi);
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_acc_starts_tick: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc |=> (r_state == S_ERR)
    ) else $error("accepted item did not start error computation");

    a_result_loaded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLAMP) && out_free |=> r_out_valid && (r_state == S_IDLE)
    ) else $error("finished item was not loaded into the output register");

    a_rem_below_dvs: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && !r_ovf |-> (r_rem < r_dvs)
    ) else $error("divider remainder reached the divisor");

    a_term_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_term < TERM_W'(NUM_TERMS))
    ) else $error("product index out of range");

endmodule

>>> test/wfpd_drive_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wfpd_drive_checker
// Watches the register port and both item channels of the wall-following PD
// drive controller. For each accepted tick it predicts the two motor speeds,
// then compares every delivered drive item with the oldest prediction.
// ----------------------------------------------------------------------------
module wfpd_drive_checker #(
    parameter int TICK_WIDTH   = 24,
    parameter int SENSOR_WIDTH = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wfpd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wfpd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_cmd_valid,
    input  logic                             i_cmd_ready,
    input  logic signed [TICK_WIDTH-1:0]     i_cmd_encoder_one,
    input  logic signed [TICK_WIDTH-1:0]     i_cmd_encoder_two,
    input  logic [SENSOR_WIDTH-1:0]          i_cmd_left_ir,
    input  logic [SENSOR_WIDTH-1:0]          i_cmd_right_ir,
    input  logic [wfpd_pkg::MODE_W-1:0]      i_cmd_mode,
    input  logic                             i_cmd_restart,
    input  logic                             i_drive_valid,
    input  logic                             i_drive_ready,
    input  logic [wfpd_pkg::SPEED_W-1:0]     i_drive_motor_one_speed,
    input  logic [wfpd_pkg::SPEED_W-1:0]     i_drive_motor_two_speed,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked
);
    import wfpd_pkg::*;

    typedef struct packed {
        logic [SPEED_W-1:0] motor_one;
        logic [SPEED_W-1:0] motor_two;
    } t_speeds;

    logic [31:0]           vel_pd;
    logic [31:0]           ang_pd;
    logic [31:0]           wall_pd;
    logic [DIV_W-1:0]      sum_divisor;
    logic [SPEED_W-1:0]    cruise_level;
    logic [15:0]           limit_pair;
    logic [SETPOINT_W-1:0] ir_target;

    longint             prev_tick_one;
    longint             prev_tick_two;
    longint             prev_vel_err;
    longint             prev_ang_err;
    longint             prev_wall_err;
    logic [MODE_W-1:0]  prev_mode;

    t_speeds expected_speeds[$];
    t_speeds want;

    function automatic longint gain_p(input logic [31:0] pair);
        return longint'($signed(pair[15:0]));
    endfunction

    function automatic longint gain_d(input logic [31:0] pair);
        return longint'($signed(pair[31:16]));
    endfunction

    function automatic logic [SPEED_W-1:0] clamp_speed(input longint value,
                                                       input longint lo,
                                                       input longint hi);
        longint clamped;
        if (value < lo) begin
            clamped = lo;
        end else if (value > hi) begin
            clamped = hi;
        end else begin
            clamped = value;
        end
        return clamped[SPEED_W-1:0];
    endfunction

    function automatic t_speeds predict_speeds(
        input logic signed [TICK_WIDTH-1:0] enc_one_in,
        input logic signed [TICK_WIDTH-1:0] enc_two_in,
        input logic [SENSOR_WIDTH-1:0]      left_in,
        input logic [SENSOR_WIDTH-1:0]      right_in,
        input logic [MODE_W-1:0]            mode_in,
        input logic                         restart_in
    );
        longint  count_one;
        longint  count_two;
        longint  left_v;
        longint  right_v;
        longint  target_v;
        longint  vel_err;
        longint  vel_der;
        longint  ang_err;
        longint  ang_der;
        longint  wall_err;
        longint  wall_der;
        longint  pd_sum;
        longint  divide_by;
        longint  correction;
        longint  speed_lo;
        longint  speed_hi;
        longint  cruise_v;
        t_speeds speeds;
        count_one = longint'(enc_one_in);
        count_two = longint'(enc_two_in);
        left_v    = longint'(left_in);
        right_v   = longint'(right_in);
        target_v  = longint'(ir_target);

        if (restart_in || mode_in != prev_mode) begin
            prev_vel_err  = 0;
            prev_ang_err  = 0;
            prev_wall_err = 0;
            prev_tick_one = count_one;
            prev_tick_two = count_two;
        end
        prev_mode = mode_in;

        vel_err = (count_two - prev_tick_two) - (count_one - prev_tick_one);
        vel_der = vel_err - prev_vel_err;
        ang_err = count_two - count_one;
        ang_der = ang_err - prev_ang_err;
        case (mode_in)
            MODE_LEFT: begin
                wall_err = left_v - target_v;
            end
            MODE_RIGHT: begin
                wall_err = target_v - right_v;
            end
            MODE_BOTH: begin
                wall_err = left_v - right_v;
            end
            default: begin
                wall_err = 0;
            end
        endcase
        wall_der = wall_err - prev_wall_err;

        prev_tick_one = count_one;
        prev_tick_two = count_two;
        prev_vel_err  = vel_err;
        prev_ang_err  = ang_err;
        prev_wall_err = wall_err;

        pd_sum = gain_p(vel_pd) * vel_err + gain_d(vel_pd) * vel_der
               + gain_p(ang_pd) * ang_err + gain_d(ang_pd) * ang_der
               + gain_p(wall_pd) * wall_err + gain_d(wall_pd) * wall_der;

        if (sum_divisor == '0) begin
            divide_by = 1;
        end else begin
            divide_by = longint'(sum_divisor);
        end
        correction = pd_sum / divide_by;

        speed_lo = longint'(limit_pair[7:0]);
        speed_hi = longint'(limit_pair[15:8]);
        cruise_v = longint'(cruise_level);
        speeds.motor_one = clamp_speed(cruise_v + correction, speed_lo, speed_hi);
        speeds.motor_two = clamp_speed(cruise_v - correction, speed_lo, speed_hi);
        return speeds;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vel_pd        = '0;
            ang_pd        = '0;
            wall_pd       = '0;
            sum_divisor   = DIVISOR_RST;
            cruise_level  = '0;
            limit_pair    = LIMITS_RST;
            ir_target     = '0;
            prev_tick_one = 0;
            prev_tick_two = 0;
            prev_vel_err  = 0;
            prev_ang_err  = 0;
            prev_wall_err = 0;
            prev_mode     = MODE_NONE;
            expected_speeds.delete();
            o_fail_count  = 0;
            o_checked     = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_VEL_GAINS: begin
                        vel_pd = i_cfg_data;
                    end
                    REG_ANG_GAINS: begin
                        ang_pd = i_cfg_data;
                    end
                    REG_WALL_GAINS: begin
                        wall_pd = i_cfg_data;
                    end
                    REG_DIVISOR: begin
                        sum_divisor = i_cfg_data[DIV_W-1:0];
                    end
                    REG_CRUISE: begin
                        cruise_level = i_cfg_data[SPEED_W-1:0];
                    end
                    REG_LIMITS: begin
                        limit_pair = i_cfg_data[15:0];
                    end
                    REG_SETPOINT: begin
                        ir_target = i_cfg_data[SETPOINT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (i_drive_valid && i_drive_ready) begin
                if (expected_speeds.size() == 0) begin
                    $error("drive item with no tick outstanding: motor_one_speed %0d, %s %0d",
                           i_drive_motor_one_speed, "motor_two_speed",
                           i_drive_motor_two_speed);
                    o_fail_count++;
                end else begin
                    want = expected_speeds.pop_front();
                    o_checked++;
                    if (i_drive_motor_one_speed !== want.motor_one) begin
                        $error("motor_one_speed: expected %0d, actual %0d",
                               want.motor_one, i_drive_motor_one_speed);
                        o_fail_count++;
                    end
                    if (i_drive_motor_two_speed !== want.motor_two) begin
                        $error("motor_two_speed: expected %0d, actual %0d",
                               want.motor_two, i_drive_motor_two_speed);
                        o_fail_count++;
                    end
                end
            end

            if (i_cmd_valid && i_cmd_ready) begin
                expected_speeds.push_back(predict_speeds(i_cmd_encoder_one,
                                                         i_cmd_encoder_two,
                                                         i_cmd_left_ir,
                                                         i_cmd_right_ir,
                                                         i_cmd_mode,
                                                         i_cmd_restart));
            end
        end
        o_pending = expected_speeds.size();
    end

endmodule

>>> test/wall_following_pd_drive_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wall_following_pd_drive_top_tb
// Drives control ticks into the wall-following PD drive controller through a
// directed set of corner cases and then many phases of random or extreme
// register settings and tick sequences, with bursty input and a stalling
// receiver. A separate checker predicts and compares every drive item.
// ----------------------------------------------------------------------------
module wall_following_pd_drive_top_tb;
    import wfpd_pkg::*;

    localparam int TICK_WIDTH      = 24;
    localparam int SENSOR_WIDTH    = 12;
    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 12;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int DRAIN_CYCLES    = 100;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int IR_MAX          = (1 << SENSOR_WIDTH) - 1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic signed [TICK_WIDTH-1:0] enc_one;
        logic signed [TICK_WIDTH-1:0] enc_two;
        logic [SENSOR_WIDTH-1:0]      left_ir;
        logic [SENSOR_WIDTH-1:0]      right_ir;
        logic [MODE_W-1:0]            mode;
        logic                         restart;
    } t_tick;

    typedef struct {
        logic [31:0]           vel_gains;
        logic [31:0]           ang_gains;
        logic [31:0]           wall_gains;
        logic [DIV_W-1:0]      divisor;
        logic [SPEED_W-1:0]    cruise;
        logic [15:0]           limits;
        logic [SETPOINT_W-1:0] setpoint;
    } t_drive_settings;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int          fail_count;
    int          pending_cnt;
    int          checked_cnt;
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    bit          gaps_on;
    bit          stalls_on;
    int          stall_run = 0;
    logic        stall_level = 1'b1;
    int          ticks_sent = 0;
    int          settings_done = 0;

    wfpd_in_if #(.TICK_WIDTH(TICK_WIDTH), .SENSOR_WIDTH(SENSOR_WIDTH)) cmd_if ();
    wfpd_out_if drive_if ();

    wall_following_pd_drive_top #(
        .TICK_WIDTH   (TICK_WIDTH),
        .SENSOR_WIDTH (SENSOR_WIDTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_if),
        .o_drive    (drive_if)
    );

    wfpd_drive_checker #(
        .TICK_WIDTH   (TICK_WIDTH),
        .SENSOR_WIDTH (SENSOR_WIDTH)
    ) u_checker (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_we                (cfg_we),
        .i_cfg_idx               (cfg_idx),
        .i_cfg_data              (cfg_data),
        .i_cmd_valid             (cmd_if.valid),
        .i_cmd_ready             (cmd_if.ready),
        .i_cmd_encoder_one       (cmd_if.encoder_one),
        .i_cmd_encoder_two       (cmd_if.encoder_two),
        .i_cmd_left_ir           (cmd_if.left_ir),
        .i_cmd_right_ir          (cmd_if.right_ir),
        .i_cmd_mode              (cmd_if.mode),
        .i_cmd_restart           (cmd_if.restart),
        .i_drive_valid           (drive_if.valid),
        .i_drive_ready           (drive_if.ready),
        .i_drive_motor_one_speed (drive_if.motor_one_speed),
        .i_drive_motor_two_speed (drive_if.motor_two_speed),
        .o_fail_count            (fail_count),
        .o_pending               (pending_cnt),
        .o_checked               (checked_cnt)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver alternates runs of ready and stalled cycles, mostly ready.
    always @(negedge i_clk) begin
        if (!stalls_on) begin
            drive_if.ready <= 1'b1;
        end else begin
            if (stall_run == 0) begin
                stall_run   = $urandom_range(1, 40);
                stall_level = ($urandom_range(0, 2) != 0);
            end
            stall_run--;
            drive_if.ready <= stall_level;
        end
    end

    function automatic t_tick make_tick(input int enc_one, input int enc_two,
                                        input int left_ir, input int right_ir,
                                        input logic [MODE_W-1:0] mode,
                                        input logic restart);
        t_tick t;
        t.enc_one  = enc_one[TICK_WIDTH-1:0];
        t.enc_two  = enc_two[TICK_WIDTH-1:0];
        t.left_ir  = left_ir[SENSOR_WIDTH-1:0];
        t.right_ir = right_ir[SENSOR_WIDTH-1:0];
        t.mode     = mode;
        t.restart  = restart;
        return t;
    endfunction

    function automatic int clip_ir(input int value);
        if (value < 0) begin
            return 0;
        end else if (value > IR_MAX) begin
            return IR_MAX;
        end
        return value;
    endfunction

    function automatic logic [31:0] pack_gains(input int kp, input int kd);
        return {kd[15:0], kp[15:0]};
    endfunction

    function automatic int random_gain();
        case ($urandom_range(0, 9))
            0: return 32767;
            1: return -32768;
            default: return int'($urandom_range(0, 512)) - 256;
        endcase
    endfunction

    task automatic send_tick(input t_tick t);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = gaps_on ? $urandom_range(0, 90) : 0;
            if (gap > 0) begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        cmd_if.valid       <= 1'b1;
        cmd_if.encoder_one <= t.enc_one;
        cmd_if.encoder_two <= t.enc_two;
        cmd_if.left_ir     <= t.left_ir;
        cmd_if.right_ir    <= t.right_ir;
        cmd_if.mode        <= t.mode;
        cmd_if.restart     <= t.restart;
        do begin
            @(posedge i_clk);
        end while (!cmd_if.ready);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        cmd_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_cnt != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic program_regs(input t_drive_settings s);
        write_reg(REG_VEL_GAINS, s.vel_gains);
        write_reg(REG_ANG_GAINS, s.ang_gains);
        write_reg(REG_WALL_GAINS, s.wall_gains);
        write_reg(REG_DIVISOR, CFG_DATA_W'(s.divisor));
        write_reg(REG_CRUISE, CFG_DATA_W'(s.cruise));
        write_reg(REG_LIMITS, CFG_DATA_W'(s.limits));
        write_reg(REG_SETPOINT, CFG_DATA_W'(s.setpoint));
        write_reg(REG_UNUSED, $urandom());
        cfg_we <= 1'b0;
        settings_done++;
    endtask

    initial begin
        t_drive_settings  s;
        t_tick            t;
        int               seg_len;
        int               step_one;
        logic [MODE_W-1:0] seg_mode;
        logic signed [TICK_WIDTH-1:0] run_one;
        logic signed [TICK_WIDTH-1:0] run_two;
        int               sent;

        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        cmd_if.valid       = 1'b0;
        cmd_if.encoder_one = '0;
        cmd_if.encoder_two = '0;
        cmd_if.left_ir     = '0;
        cmd_if.right_ir    = '0;
        cmd_if.mode        = MODE_NONE;
        cmd_if.restart     = 1'b0;
        gaps_on            = 1'b1;
        stalls_on          = 1'b1;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset defaults first, then corner cases under two fixed settings.
        send_tick(make_tick(100, -100, 0, 0, MODE_NONE, 1'b1));
        send_tick(make_tick(-5, 7, IR_MAX, IR_MAX, MODE_BOTH, 1'b0));
        wait_idle();

        s.vel_gains  = pack_gains(3, -2);
        s.ang_gains  = pack_gains(2, 4);
        s.wall_gains = pack_gains(1, -3);
        s.divisor    = '0;
        s.cruise     = 8'd128;
        s.limits     = {8'd240, 8'd10};
        s.setpoint   = 12'd2000;
        program_regs(s);
        send_tick(make_tick(0, 0, 2000, 2000, MODE_NONE, 1'b1));
        send_tick(make_tick(10, 14, 2000, 2000, MODE_NONE, 1'b0));
        send_tick(make_tick(25, 20, 2000, 2000, MODE_NONE, 1'b0));
        send_tick(make_tick(30, 31, IR_MAX, 0, MODE_LEFT, 1'b0));
        send_tick(make_tick(40, 41, 0, 0, MODE_LEFT, 1'b0));
        send_tick(make_tick(50, 50, 0, IR_MAX, MODE_RIGHT, 1'b0));
        send_tick(make_tick(60, 60, IR_MAX, 0, MODE_RIGHT, 1'b0));
        send_tick(make_tick(70, 72, IR_MAX, 0, MODE_BOTH, 1'b0));
        send_tick(make_tick(80, 80, 0, IR_MAX, MODE_BOTH, 1'b0));
        send_tick(make_tick(90, 95, 1000, 3000, MODE_BOTH, 1'b1));
        send_tick(make_tick(8388607, -8388608, IR_MAX, 0, MODE_BOTH, 1'b0));
        send_tick(make_tick(-8388608, 8388607, 0, IR_MAX, MODE_BOTH, 1'b0));
        send_tick(make_tick(-8388608, -8388608, 0, 0, MODE_NONE, 1'b0));
        wait_idle();

        s.vel_gains  = pack_gains(32767, -32768);
        s.ang_gains  = pack_gains(-32768, 32767);
        s.wall_gains = pack_gains(32767, 32767);
        s.divisor    = 16'hFFFF;
        s.cruise     = 8'd100;
        s.limits     = {8'd50, 8'd200};
        s.setpoint   = 12'hFFF;
        program_regs(s);
        send_tick(make_tick(0, 0, 0, 0, MODE_NONE, 1'b1));
        send_tick(make_tick(1000, -1000, 0, 0, MODE_NONE, 1'b0));
        send_tick(make_tick(-1000, 1000, 0, 0, MODE_NONE, 1'b0));
        send_tick(make_tick(8388607, 8388607, IR_MAX, 0, MODE_LEFT, 1'b0));
        send_tick(make_tick(0, 0, 0, IR_MAX, MODE_RIGHT, 1'b0));
        send_tick(make_tick(12, -30, 0, IR_MAX, MODE_RIGHT, 1'b0));

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            gaps_on   = (phase % 4 != 3);
            stalls_on = (phase % 3 != 2);
            if (phase == 1) begin
                s.vel_gains  = pack_gains(32767, 32767);
                s.ang_gains  = pack_gains(32767, 32767);
                s.wall_gains = pack_gains(32767, 32767);
                s.divisor    = 16'hFFFF;
                s.cruise     = 8'hFF;
                s.limits     = 16'hFFFF;
                s.setpoint   = 12'hFFF;
            end else if (phase == 2) begin
                s.vel_gains  = pack_gains(-32768, -32768);
                s.ang_gains  = pack_gains(-32768, -32768);
                s.wall_gains = pack_gains(-32768, -32768);
                s.divisor    = '0;
                s.cruise     = '0;
                s.limits     = '0;
                s.setpoint   = '0;
            end else begin
                s.vel_gains  = pack_gains(random_gain(), random_gain());
                s.ang_gains  = pack_gains(random_gain(), random_gain());
                s.wall_gains = pack_gains(random_gain(), random_gain());
                case ($urandom_range(0, 7))
                    0: s.divisor = '0;
                    1: s.divisor = 16'd1;
                    2: s.divisor = 16'hFFFF;
                    default: s.divisor = DIV_W'($urandom_range(16, 2048));
                endcase
                case ($urandom_range(0, 5))
                    0: s.cruise = '0;
                    1: s.cruise = 8'hFF;
                    default: s.cruise = SPEED_W'($urandom_range(40, 215));
                endcase
                case ($urandom_range(0, 6))
                    0: s.limits = LIMITS_RST;
                    1: s.limits = {8'($urandom_range(0, 120)), 8'($urandom_range(130, 255))};
                    2: s.limits = 16'($urandom());
                    default: s.limits = {8'($urandom_range(150, 255)),
                                         8'($urandom_range(0, 100))};
                endcase
                case ($urandom_range(0, 5))
                    0: s.setpoint = '0;
                    1: s.setpoint = 12'hFFF;
                    default: s.setpoint = SETPOINT_W'($urandom());
                endcase
            end
            program_regs(s);

            // Mostly smooth drive runs under one mode; the rest is raw noise.
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 4) == 0) begin
                    t.enc_one  = TICK_WIDTH'($urandom());
                    t.enc_two  = TICK_WIDTH'($urandom());
                    t.left_ir  = SENSOR_WIDTH'($urandom());
                    t.right_ir = SENSOR_WIDTH'($urandom());
                    t.mode     = MODE_W'($urandom());
                    t.restart  = 1'($urandom());
                    send_tick(t);
                    sent++;
                end else begin
                    seg_len  = $urandom_range(4, 30);
                    seg_mode = MODE_W'($urandom());
                    run_one  = TICK_WIDTH'($urandom());
                    run_two  = TICK_WIDTH'(int'(run_one) +
                                           (int'($urandom_range(0, 64)) - 32));
                    for (int k = 0; k < seg_len; k++) begin
                        step_one = int'($urandom_range(0, 60)) - 10;
                        run_one  = TICK_WIDTH'(int'(run_one) + step_one);
                        run_two  = TICK_WIDTH'(int'(run_two) + step_one +
                                               (int'($urandom_range(0, 16)) - 8));
                        t.enc_one  = run_one;
                        t.enc_two  = run_two;
                        t.left_ir  = SENSOR_WIDTH'(clip_ir(int'(s.setpoint) +
                                             int'($urandom_range(0, 600)) - 300));
                        t.right_ir = SENSOR_WIDTH'(clip_ir(int'(s.setpoint) +
                                             int'($urandom_range(0, 600)) - 300));
                        t.mode     = seg_mode;
                        t.restart  = (k == 0 && $urandom_range(0, 1) == 1) ||
                                     ($urandom_range(0, 15) == 0);
                        send_tick(t);
                        sent++;
                    end
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d control ticks under %0d register settings; %0d drive items checked.",
                 ticks_sent, settings_done, checked_cnt);
        if (fail_count == 0 && pending_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
